/* hw/rtl/rie_pkg.sv */
// shared types, constants and decoded instruction format of the execute unit
package rie_pkg;

  localparam int ADDR_BITS  = 10;
  localparam int DATA_WORDS = 256;
  localparam int DS_AW      = $clog2(DATA_WORDS);
  localparam int REG_NUM    = 16;
  localparam int RF_AW      = 4;
  localparam int QDEPTH     = 2;
  localparam int QAW        = 1;
  localparam int OP_LAST    = 20;

  localparam logic [31:0] IMM_MASK  = 32'h0000_0FFF;
  localparam logic [31:0] IMM_SIGN  = 32'h0000_0800;
  localparam logic [31:0] IMM_FILL  = 32'hFFFF_F000;
  localparam logic [3:0]  REG_ZERO  = 4'd0;
  localparam logic [3:0]  REG_IMM   = 4'd1;
  localparam logic [3:0]  REG_LINK  = 4'hf;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_AND  = 5'd2,
    OP_OR   = 5'd3,
    OP_XOR  = 5'd4,
    OP_MUL  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRA  = 5'd7,
    OP_SRL  = 5'd8,
    OP_BEQ  = 5'd9,
    OP_BNE  = 5'd10,
    OP_BLT  = 5'd11,
    OP_BGT  = 5'd12,
    OP_BLE  = 5'd13,
    OP_BGE  = 5'd14,
    OP_JAL  = 5'd15,
    OP_LW   = 5'd16,
    OP_SW   = 5'd17,
    OP_LL   = 5'd18,
    OP_SC   = 5'd19,
    OP_HALT = 5'd20,
    OP_NOP  = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    SRC_ALU = 2'd0,
    SRC_MUL = 2'd1,
    SRC_MEM = 2'd2
  } src_t;

  typedef struct packed {
    logic [31:0]          instruction_word;
    logic [ADDR_BITS-1:0] instr_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] next_addr;
    logic                 halted;
    logic                 reg_written;
    logic [3:0]           written_reg;
    logic signed [31:0]   written_value;
  } out_t;

  typedef struct packed {
    op_t                  op;
    logic [RF_AW-1:0]     rd;
    logic [RF_AW-1:0]     rs;
    logic [RF_AW-1:0]     rt;
    logic [31:0]          imm;
    logic [ADDR_BITS-1:0] pc;
    logic [ADDR_BITS:0]   pc_inc;
    logic                 wr;
    logic [RF_AW-1:0]     wreg;
  } dec_t;

endpackage

/* hw/rtl/rie_front.sv */
// front end: field extraction, immediate extension and instruction classification
module rie_front (
  input  rie_pkg::in_t  in_data,
  output rie_pkg::dec_t dec
);
  import rie_pkg::*;

  logic [7:0]  opcode;
  logic [31:0] imm_raw;
  logic        wr_class;

  assign opcode  = in_data.instruction_word[31:24];
  assign imm_raw = in_data.instruction_word & IMM_MASK;

  always_comb begin
    dec.rd     = in_data.instruction_word[23:20];
    dec.rs     = in_data.instruction_word[19:16];
    dec.rt     = in_data.instruction_word[15:12];
    dec.imm    = ((imm_raw & IMM_SIGN) != '0) ? (imm_raw | IMM_FILL) : imm_raw;
    dec.pc     = in_data.instr_addr;
    dec.pc_inc = {1'b0, in_data.instr_addr} + {{ADDR_BITS{1'b0}}, 1'b1};
    if (opcode <= 8'(OP_LAST)) begin
      dec.op = op_t'(opcode[4:0]);
    end else begin
      dec.op = OP_NOP;
    end
    unique case (dec.op)
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_MUL, OP_SLL, OP_SRA, OP_SRL,
      OP_LW, OP_LL, OP_SC: wr_class = 1'b1;
      default:             wr_class = 1'b0;
    endcase
    // writes to the zero and immediate registers are dropped
    if (dec.op == OP_JAL) begin
      dec.wr   = 1'b1;
      dec.wreg = REG_LINK;
    end else if (wr_class && (dec.rd != REG_ZERO) && (dec.rd != REG_IMM)) begin
      dec.wr   = 1'b1;
      dec.wreg = dec.rd;
    end else begin
      dec.wr   = 1'b0;
      dec.wreg = REG_ZERO;
    end
  end

endmodule

/* hw/rtl/rie_queue.sv */
// two-entry queue of decoded instructions between front and back end
module rie_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rie_pkg::dec_t push_data,
  input  logic          pop,
  output rie_pkg::dec_t head,
  output logic          full,
  output logic          empty
);
  import rie_pkg::*;

  dec_t           mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    priority case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/rie_regfile.sv */
// 16 x 32 register file copy, one write port, three registered read ports
module rie_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [rie_pkg::RF_AW-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [rie_pkg::RF_AW-1:0] raddr0,
  input  logic [rie_pkg::RF_AW-1:0] raddr1,
  input  logic [rie_pkg::RF_AW-1:0] raddr2,
  output logic [31:0]               rdata0,
  output logic [31:0]               rdata1,
  output logic [31:0]               rdata2
);
  import rie_pkg::*;

  logic [31:0]        mem [REG_NUM];
  logic [REG_NUM-1:0] vld_r;
  logic [31:0]        rdata0_r;
  logic [31:0]        rdata1_r;
  logic [31:0]        rdata2_r;

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;
  assign rdata2 = rdata2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= vld_r[raddr0] ? mem[raddr0] : '0;
      rdata1_r <= vld_r[raddr1] ? mem[raddr1] : '0;
      rdata2_r <= vld_r[raddr2] ? mem[raddr2] : '0;
    end
  end

endmodule

/* hw/rtl/rie_back.sv */
// back end: operand read, execute stage, data store and writeback/output stage
module rie_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rie_pkg::dec_t head,
  input  logic          q_empty,
  output logic          issue,
  output logic          out_valid,
  input  logic          out_ready,
  output rie_pkg::out_t out_data
);
  import rie_pkg::*;

  // execute stage
  logic        x_vld_r, x_vld_nxt;
  dec_t        x_dec_r;
  logic        x_adv;
  logic [31:0] rf_a, rf_b, rf_d;
  logic [31:0] a, b, d;
  logic [31:0] alu;
  logic [63:0] prod;
  logic        take;
  logic        is_store;
  logic [DS_AW-1:0]     ds_addr;
  logic [31:0]          addr_sum;
  logic [ADDR_BITS-1:0] target;
  logic [ADDR_BITS-1:0] next;
  src_t        src;

  // writeback stage
  logic                 w_vld_r, w_vld_nxt;
  logic [ADDR_BITS-1:0] w_next_r;
  logic                 w_halt_r;
  logic                 w_wr_r;
  logic [RF_AW-1:0]     w_wreg_r;
  src_t                 w_src_r;
  logic [31:0]          w_alu_r;
  logic [31:0]          w_mul_r;
  logic [31:0]          ld_data_r;
  logic [31:0]          w_val;
  logic                 retire;

  // most recent register write, covers the read issued at the same edge
  logic             lr_vld_r;
  logic [RF_AW-1:0] lr_reg_r;
  logic [31:0]      lr_val_r;

  // data store
  logic [31:0]           ds_mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] ds_vld_r;

  assign retire = w_vld_r && out_ready;
  assign x_adv  = x_vld_r && (!w_vld_r || out_ready);
  assign issue  = !q_empty && (!x_vld_r || x_adv);

  rie_regfile u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (retire && w_wr_r),
    .waddr  (w_wreg_r),
    .wdata  (w_val),
    .re     (issue),
    .raddr0 (head.rs),
    .raddr1 (head.rt),
    .raddr2 (head.rd),
    .rdata0 (rf_a),
    .rdata1 (rf_b),
    .rdata2 (rf_d)
  );

  always_comb begin
    unique case (w_src_r)
      SRC_MUL: w_val = w_mul_r;
      SRC_MEM: w_val = ld_data_r;
      default: w_val = w_alu_r;
    endcase
  end

  function automatic logic [31:0] operand(
    input logic [RF_AW-1:0] idx,
    input logic [31:0]      rf,
    input logic [31:0]      imm,
    input logic             w_hit_en,
    input logic [RF_AW-1:0] w_reg,
    input logic [31:0]      w_value,
    input logic             lr_en,
    input logic [RF_AW-1:0] lr_reg,
    input logic [31:0]      lr_value
  );
    logic [31:0] v;
    if (idx == REG_ZERO) begin
      v = '0;
    end else if (idx == REG_IMM) begin
      v = imm;
    end else if (w_hit_en && (w_reg == idx)) begin
      v = w_value;
    end else if (lr_en && (lr_reg == idx)) begin
      v = lr_value;
    end else begin
      v = rf;
    end
    return v;
  endfunction

  always_comb begin
    a = operand(x_dec_r.rs, rf_a, x_dec_r.imm, w_vld_r && w_wr_r, w_wreg_r, w_val,
                lr_vld_r, lr_reg_r, lr_val_r);
    b = operand(x_dec_r.rt, rf_b, x_dec_r.imm, w_vld_r && w_wr_r, w_wreg_r, w_val,
                lr_vld_r, lr_reg_r, lr_val_r);
    d = operand(x_dec_r.rd, rf_d, x_dec_r.imm, w_vld_r && w_wr_r, w_wreg_r, w_val,
                lr_vld_r, lr_reg_r, lr_val_r);
    prod     = a * b;
    addr_sum = a + b;
    ds_addr  = addr_sum[DS_AW-1:0];
    src      = SRC_ALU;
    alu      = '0;
    take     = 1'b0;
    is_store = 1'b0;
    unique case (x_dec_r.op)
      OP_ADD: alu = addr_sum;
      OP_SUB: alu = a - b;
      OP_AND: alu = a & b;
      OP_OR:  alu = a | b;
      OP_XOR: alu = a ^ b;
      OP_MUL: src = SRC_MUL;
      OP_SLL: alu = (b[31:5] != '0) ? '0 : (a << b[4:0]);
      OP_SRA: alu = (b[31:5] != '0) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      OP_SRL: alu = (b[31:5] != '0) ? '0 : (a >> b[4:0]);
      OP_BEQ: take = (a == b);
      OP_BNE: take = (a != b);
      OP_BLT: take = ($signed(a) < $signed(b));
      OP_BGT: take = ($signed(b) < $signed(a));
      OP_BLE: take = !($signed(b) < $signed(a));
      OP_BGE: take = !($signed(a) < $signed(b));
      OP_JAL: begin
        alu  = {{(32-ADDR_BITS-1){1'b0}}, x_dec_r.pc_inc};
        take = 1'b1;
      end
      OP_LW, OP_LL: src = SRC_MEM;
      OP_SW: is_store = 1'b1;
      OP_SC: begin
        is_store = 1'b1;
        alu      = 32'd1;
      end
      default: ;
    endcase
    // jal through the link register lands on the new link value
    if ((x_dec_r.op == OP_JAL) && (x_dec_r.rd == REG_LINK)) begin
      target = x_dec_r.pc_inc[ADDR_BITS-1:0];
    end else begin
      target = d[ADDR_BITS-1:0];
    end
    if (x_dec_r.op == OP_HALT) begin
      next = x_dec_r.pc;
    end else if (take) begin
      next = target;
    end else begin
      next = x_dec_r.pc_inc[ADDR_BITS-1:0];
    end
    x_vld_nxt = issue ? 1'b1 : (x_adv ? 1'b0 : x_vld_r);
    w_vld_nxt = x_adv ? 1'b1 : (retire ? 1'b0 : w_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r  <= 1'b0;
      w_vld_r  <= 1'b0;
      lr_vld_r <= 1'b0;
      ds_vld_r <= '0;
    end else begin
      x_vld_r <= x_vld_nxt;
      w_vld_r <= w_vld_nxt;
      if (retire && w_wr_r) begin
        lr_vld_r <= 1'b1;
      end
      if (x_adv && is_store) begin
        ds_vld_r[ds_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      x_dec_r <= head;
    end
    if (retire && w_wr_r) begin
      lr_reg_r <= w_wreg_r;
      lr_val_r <= w_val;
    end
    if (x_adv) begin
      w_next_r <= next;
      w_halt_r <= (x_dec_r.op == OP_HALT);
      w_wr_r   <= x_dec_r.wr;
      w_wreg_r <= x_dec_r.wreg;
      w_src_r  <= src;
      w_alu_r  <= alu;
      w_mul_r  <= prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (x_adv && is_store) begin
      ds_mem[ds_addr] <= d;
    end
    if (x_adv) begin
      ld_data_r <= ds_vld_r[ds_addr] ? ds_mem[ds_addr] : '0;
    end
  end

  assign out_valid              = w_vld_r;
  assign out_data.next_addr     = w_next_r;
  assign out_data.halted        = w_halt_r;
  assign out_data.reg_written   = w_wr_r;
  assign out_data.written_reg   = w_wr_r ? w_wreg_r : REG_ZERO;
  assign out_data.written_value = w_wr_r ? $signed(w_val) : 32'sd0;

endmodule

/* hw/rtl/risc_instruction_execute_top.sv */
// top level of the instruction execute unit
// in channel: in_valid/in_ready transfer one instruction word and its address.
// out channel: out_valid/out_ready transfer one result per instruction: next
// address, halt flag and the register write (index and value) if any.
// front end decodes each instruction into a two-entry queue; the back end reads
// the register file, executes (alu, branch compare, multiplier, data store
// access) and holds the result in the output register, which also writes back.
// each result passes through the queue, the execute stage and the output register.
// throughput: one instruction per cycle while out_ready is high, with back-to-back dependent
// instructions served by forwarding from the output register and last write.
// loads read the 256-word data store through a registered port, one per cycle while not stalled.
// reset: synchronous active-low rst_n empties the queue and stages and clears
// the register file and data store to zero at once through valid bits.
// when out_ready is low the output register holds its result, the execute
// stage and then the queue fill, and in_ready drops once the queue is full.
module risc_instruction_execute_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rie_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rie_pkg::out_t out_data
);
  import rie_pkg::*;

  dec_t dec;
  dec_t head;
  logic q_full;
  logic q_empty;
  logic issue;

  assign in_ready = !q_full;

  rie_front u_front (
    .in_data (in_data),
    .dec     (dec)
  );

  rie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (dec),
    .pop       (issue),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .issue     (issue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench of the instruction execute unit: directed instruction table, then random instructions
module tb;
  import rie_pkg::*;

  localparam int ITEM_COUNT     = 1950;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int HOLD_AT_RESULT = 600;
  localparam int HOLD_CYCLES    = 250;
  localparam int DRAIN_AT_ITEM  = 1200;
  localparam int TAIL_CYCLES    = 20;
  localparam int PC_MAX         = (1 << ADDR_BITS) - 1;
  localparam logic [7:0] OPC_TOP = 8'hFF;

  typedef struct {
    logic [31:0]          word;
    logic [ADDR_BITS-1:0] pc;
    bit                   typed;
    logic [ADDR_BITS-1:0] next_addr;
    logic                 halted;
    logic                 reg_written;
    logic [3:0]           written_reg;
    logic [31:0]          written_value;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic [31:0] gpr_model [REG_NUM];
  logic [31:0] dstore_model [DATA_WORDS];
  out_t pending_results [$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  risc_instruction_execute_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] encode_instr(logic [7:0] opc, logic [3:0] rd, logic [3:0] rs,
                                               logic [3:0] rt, logic [11:0] imm);
    return {opc, rd, rs, rt, imm};
  endfunction

  function automatic logic [31:0] read_gpr(logic [3:0] idx, logic [31:0] immx);
    if (idx == REG_ZERO) return 32'd0;
    if (idx == REG_IMM) return immx;
    return gpr_model[idx];
  endfunction

  function automatic out_t execute_instr(in_t item);
    logic [7:0] opc;
    logic [3:0] rd, rs, rt, wreg;
    logic [31:0] immx, a, b, sum, tgt, wval;
    logic [DS_AW-1:0] maddr;
    logic [ADDR_BITS-1:0] nxt;
    logic wr, take, halt;
    op_t op;
    out_t res;
    opc  = item.instruction_word[31:24];
    rd   = item.instruction_word[23:20];
    rs   = item.instruction_word[19:16];
    rt   = item.instruction_word[15:12];
    immx = {{20{item.instruction_word[11]}}, item.instruction_word[11:0]};
    a    = read_gpr(rs, immx);
    b    = read_gpr(rt, immx);
    sum  = a + b;
    maddr = sum[DS_AW-1:0];
    nxt  = item.instr_addr + 1'b1;
    wr   = 1'b0;
    take = 1'b0;
    halt = 1'b0;
    wreg = rd;
    wval = 32'd0;
    op   = (opc > OP_LAST) ? OP_NOP : op_t'(opc[4:0]);
    case (op)
      OP_ADD: begin wr = 1'b1; wval = a + b; end
      OP_SUB: begin wr = 1'b1; wval = a - b; end
      OP_AND: begin wr = 1'b1; wval = a & b; end
      OP_OR:  begin wr = 1'b1; wval = a | b; end
      OP_XOR: begin wr = 1'b1; wval = a ^ b; end
      OP_MUL: begin wr = 1'b1; wval = a * b; end
      OP_SLL: begin wr = 1'b1; wval = (b >= 32) ? 32'd0 : a << b[4:0]; end
      OP_SRA: begin
        wr = 1'b1;
        wval = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      end
      OP_SRL: begin wr = 1'b1; wval = (b >= 32) ? 32'd0 : a >> b[4:0]; end
      OP_BEQ: take = (a == b);
      OP_BNE: take = (a != b);
      OP_BLT: take = ($signed(a) < $signed(b));
      OP_BGT: take = ($signed(a) > $signed(b));
      OP_BLE: take = ($signed(a) <= $signed(b));
      OP_BGE: take = ($signed(a) >= $signed(b));
      OP_JAL: begin
        // link lands before the target read, so jal through r15 returns pc+1
        wr = 1'b1;
        wreg = REG_LINK;
        wval = 32'(item.instr_addr) + 32'd1;
        gpr_model[REG_LINK] = wval;
        take = 1'b1;
      end
      OP_LW, OP_LL: begin wr = 1'b1; wval = dstore_model[maddr]; end
      OP_SW: dstore_model[maddr] = read_gpr(rd, immx);
      OP_SC: begin
        dstore_model[maddr] = read_gpr(rd, immx);
        wr = 1'b1;
        wval = 32'd1;
      end
      OP_HALT: begin halt = 1'b1; nxt = item.instr_addr; end
      default: ;
    endcase
    if (take) begin
      tgt = read_gpr(rd, immx);
      nxt = tgt[ADDR_BITS-1:0];
    end
    if (wr && wreg >= 2) begin
      gpr_model[wreg] = wval;
    end else begin
      wr = 1'b0;
      wreg = REG_ZERO;
      wval = 32'd0;
    end
    res.next_addr     = nxt;
    res.halted        = halt;
    res.reg_written   = wr;
    res.written_reg   = wreg;
    res.written_value = wval;
    return res;
  endfunction

  task automatic send_instr(input in_t item, input out_t want);
    int unsigned gap;
    bit drain;
    if (sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 19);
    drain = (sent == DRAIN_AT_ITEM);
    if (drain && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && pending_results.size() != 0) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
    sent++;
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (received % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (received == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      else stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: next_addr %0d", out_data.next_addr);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.next_addr !== want.next_addr) begin
          $error("next_addr: expected %0d, got %0d", want.next_addr, out_data.next_addr);
          mismatches++;
        end
        if (out_data.halted !== want.halted) begin
          $error("halted: expected %0d, got %0d", want.halted, out_data.halted);
          mismatches++;
        end
        if (out_data.reg_written !== want.reg_written) begin
          $error("reg_written: expected %0d, got %0d", want.reg_written, out_data.reg_written);
          mismatches++;
        end
        if (out_data.written_reg !== want.written_reg) begin
          $error("written_reg: expected %0d, got %0d", want.written_reg, out_data.written_reg);
          mismatches++;
        end
        if (out_data.written_value !== want.written_value) begin
          $error("written_value: expected %0d, got %0d", want.written_value,
                 out_data.written_value);
          mismatches++;
        end
      end
      received++;
    end
  end

  initial begin : stimulus
    dir_row_t dir_table [$];
    in_t item;
    out_t want;
    out_t predicted;
    logic [7:0] opc;
    logic [3:0] rd, rs, rt;
    logic [11:0] imm;
    foreach (gpr_model[i]) gpr_model[i] = '0;
    foreach (dstore_model[i]) dstore_model[i] = '0;

    dir_table.push_back('{encode_instr(OP_ADD, 2, 1, 0, 12'h7FF), 10'd0, 1,
                          10'd1, 1'b0, 1'b1, 4'd2, 32'h0000_07FF});
    dir_table.push_back('{encode_instr(OP_ADD, 3, 1, 1, 12'h800), 10'd1023, 1,
                          10'd0, 1'b0, 1'b1, 4'd3, 32'hFFFF_F000});
    dir_table.push_back('{encode_instr(OP_SUB, 4, 0, 1, 12'h001), 10'd5, 1,
                          10'd6, 1'b0, 1'b1, 4'd4, 32'hFFFF_FFFF});
    dir_table.push_back('{encode_instr(OP_ADD, 0, 1, 1, 12'h005), 10'd6, 1,
                          10'd7, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_ADD, 1, 2, 2, 12'h000), 10'd7, 1,
                          10'd8, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_AND, 5, 3, 4, 12'h000), 10'd8, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_OR, 6, 2, 3, 12'h000), 10'd9, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_XOR, 7, 4, 2, 12'h000), 10'd10, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_MUL, 8, 4, 4, 12'h000), 10'd11, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_ADD, 9, 1, 0, 12'h020), 10'd12, 1,
                          10'd13, 1'b0, 1'b1, 4'd9, 32'd32});
    // shift amounts of 32, then in-range shift amounts
    dir_table.push_back('{encode_instr(OP_SLL, 10, 4, 9, 12'h000), 10'd13, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SRA, 11, 3, 9, 12'h000), 10'd14, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SRL, 12, 4, 9, 12'h000), 10'd15, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SRA, 13, 3, 1, 12'h004), 10'd16, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SLL, 14, 4, 1, 12'h01F), 10'd17, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_BEQ, 1, 0, 0, 12'h3FF), 10'd20, 1,
                          10'd1023, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_BNE, 1, 0, 0, 12'h3FF), 10'd21, 1,
                          10'd22, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_BLT, 2, 4, 0, 12'h000), 10'd22, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_BGT, 2, 4, 0, 12'h000), 10'd23, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_BLE, 3, 4, 4, 12'h000), 10'd24, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_BGE, 3, 3, 4, 12'h000), 10'd25, 0, '0, '0, '0, '0, '0});
    // jal through r15 at the top address
    dir_table.push_back('{encode_instr(OP_JAL, 15, 0, 0, 12'h000), 10'd1023, 1,
                          10'd0, 1'b0, 1'b1, 4'd15, 32'd1024});
    dir_table.push_back('{encode_instr(OP_JAL, 1, 0, 0, 12'h800), 10'd40, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SW, 4, 1, 0, 12'h0FF), 10'd41, 1,
                          10'd42, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_LW, 14, 1, 0, 12'h0FF), 10'd42, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_SC, 5, 1, 1, 12'h080), 10'd43, 1,
                          10'd44, 1'b0, 1'b1, 4'd5, 32'd1});
    dir_table.push_back('{encode_instr(OP_LL, 6, 0, 0, 12'h000), 10'd44, 0, '0, '0, '0, '0, '0});
    dir_table.push_back('{encode_instr(OP_HALT, 0, 0, 0, 12'h000), 10'd50, 1,
                          10'd50, 1'b1, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OPC_TOP, 15, 15, 15, 12'hFFF), 10'd51, 1,
                          10'd52, 1'b0, 1'b0, 4'd0, 32'd0});
    dir_table.push_back('{encode_instr(OP_NOP, 2, 3, 4, 12'h000), 10'd52, 1,
                          10'd53, 1'b0, 1'b0, 4'd0, 32'd0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      item.instruction_word = dir_table[i].word;
      item.instr_addr       = dir_table[i].pc;
      predicted = execute_instr(item);
      if (dir_table[i].typed)
        want = '{dir_table[i].next_addr, dir_table[i].halted, dir_table[i].reg_written,
                 dir_table[i].written_reg, dir_table[i].written_value};
      else
        want = predicted;
      send_instr(item, want);
    end

    repeat (ITEM_COUNT) begin
      if ($urandom_range(0, 99) < 85) opc = 8'($urandom_range(0, OP_LAST));
      else opc = 8'($urandom_range(OP_LAST + 1, 255));
      rd  = 4'($urandom_range(0, 15));
      rs  = 4'($urandom_range(0, 15));
      rt  = 4'($urandom_range(0, 15));
      imm = 12'($urandom_range(0, 4095));
      // small immediates through r1 for shift amounts and nearby store words
      if ($urandom_range(0, 2) == 0) begin
        rt  = REG_IMM;
        imm = 12'($urandom_range(0, 40));
      end
      item.instruction_word = encode_instr(opc, rd, rs, rt, imm);
      item.instr_addr       = ADDR_BITS'($urandom_range(0, PC_MAX));
      send_instr(item, execute_instr(item));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
